// ===== rtl/core/sfca_pkg.sv =====
// ----------------------------------------------------------------------------
// sfca_pkg: shared types, constants and functions
// Word widths, the arctangent table and the CRC-8 byte step used by the
// frame check and angle unit.
// ----------------------------------------------------------------------------
package sfca_pkg;

  // Default values for the top-level parameters.
  localparam int CordicStagesDef  = 16;
  localparam int AngleFracBitsDef = 7;

  // Datapath widths. X and Y grow by the CORDIC gain; Z holds degrees * 2^20.
  localparam int XW    = 20;
  localparam int ZW    = 30;
  localparam int ZFRAC = 20;

  // CRC-8 polynomial and the seed after reset.
  localparam logic [7:0] CrcPoly   = 8'h1D;
  localparam logic [7:0] SeedReset = 8'hFB;

  // Fixed angles in Z units.
  localparam logic signed [ZW-1:0] Deg90  = ZW'(90 <<< ZFRAC);
  localparam logic signed [ZW-1:0] Deg180 = ZW'(180 <<< ZFRAC);

  // Register map.
  localparam logic RegCrcSeed = 1'b0;

  // X, Y and accumulated angle carried along the cell chain.
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } sfca_vec_t;

  // Frame check context carried alongside the vector.
  typedef struct packed {
    logic [7:0]      crc;       // running CRC register
    logic [2:0][7:0] rest;      // X high, Y low, Y high still to be folded in
    logic [7:0]      crc_byte;  // received check byte
    logic            byp;       // axis input, angle already exact
  } sfca_side_t;

  // One byte of CRC-8, MSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] reg_in, input logic [7:0] b);
    logic [7:0] r;
    r = reg_in ^ b;
    for (int k = 0; k < 8; k++) begin
      r = r[7] ? ((r << 1) ^ CrcPoly) : (r << 1);
    end
    return r;
  endfunction

  // atan(2^-i) in degrees * 2^20, rounded.
  function automatic logic [ZW-1:0] atan_entry(input int i);
    logic [ZW-1:0] v;
    unique case (i)
      0:  v = ZW'(47185920);
      1:  v = ZW'(27855475);
      2:  v = ZW'(14718068);
      3:  v = ZW'(7471121);
      4:  v = ZW'(3750058);
      5:  v = ZW'(1876857);
      6:  v = ZW'(938658);
      7:  v = ZW'(469357);
      8:  v = ZW'(234682);
      9:  v = ZW'(117342);
      10: v = ZW'(58671);
      11: v = ZW'(29335);
      12: v = ZW'(14668);
      13: v = ZW'(7334);
      14: v = ZW'(3667);
      15: v = ZW'(1833);
      16: v = ZW'(917);
      17: v = ZW'(458);
      18: v = ZW'(229);
      19: v = ZW'(115);
      20: v = ZW'(57);
      21: v = ZW'(29);
      22: v = ZW'(14);
      23: v = ZW'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/sfca_front.sv =====
// ----------------------------------------------------------------------------
// sfca_front: frame entry stage
// Registers an accepted frame, folds the first byte into the CRC, and turns
// X and Y into the right half plane or resolves axis inputs exactly.
// ----------------------------------------------------------------------------
module sfca_front
  import sfca_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  logic [7:0] x_low,
  input  logic [7:0] x_high,
  input  logic [7:0] y_low,
  input  logic [7:0] y_high,
  input  logic [7:0] crc_byte,
  input  logic [7:0] crc_seed,
  output logic       vld,
  output sfca_vec_t  vec,
  output sfca_side_t side
);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic                 x_zero;
  logic                 y_zero;
  sfca_vec_t            vec_next;
  sfca_side_t           side_next;

  // Sign-extend the two 16-bit fields.
  assign xs     = XW'($signed({x_high, x_low}));
  assign ys     = XW'($signed({y_high, y_low}));
  assign x_zero = ({x_high, x_low} == 16'h0000);
  assign y_zero = ({y_high, y_low} == 16'h0000);

  // Axis cases bypass the rotation; a negative X is turned by 90 degrees.
  always_comb begin
    vec_next.x = xs;
    vec_next.y = ys;
    vec_next.z = '0;
    side_next.byp = 1'b0;
    priority if (y_zero) begin
      side_next.byp = 1'b1;
      vec_next.z    = xs[XW-1] ? Deg180 : '0;
    end else if (x_zero) begin
      side_next.byp = 1'b1;
      vec_next.z    = ys[XW-1] ? -Deg90 : Deg90;
    end else if (xs[XW-1]) begin
      if (!ys[XW-1]) begin
        vec_next.x = ys;
        vec_next.y = -xs;
        vec_next.z = Deg90;
      end else begin
        vec_next.x = -ys;
        vec_next.y = xs;
        vec_next.z = -Deg90;
      end
    end else begin
      // Right half plane: the vector enters the chain as it is.
    end
    side_next.crc      = crc8_byte(crc_seed, x_low);
    side_next.rest     = {y_high, y_low, x_high};
    side_next.crc_byte = crc_byte;
  end

  // Entry register, advanced with the rest of the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= in_valid;
    end
    if (en) begin
      vec  <= vec_next;
      side <= side_next;
    end
  end

endmodule

// ===== rtl/core/sfca_cell.sv =====
// ----------------------------------------------------------------------------
// sfca_cell: one CORDIC vectoring cell
// Performs one micro-rotation with its own shift and arctangent constant; the
// first three cells also fold one frame byte into the CRC.
// ----------------------------------------------------------------------------
module sfca_cell
  import sfca_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       vld_in,
  input  sfca_vec_t  vec_in,
  input  sfca_side_t side_in,
  output logic       vld,
  output sfca_vec_t  vec,
  output sfca_side_t side
);

  localparam logic signed [ZW-1:0] Atan = atan_entry(IDX);

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  sfca_vec_t            vec_next;
  sfca_side_t           side_next;
  logic [7:0]           crc_next;

  assign dx = vec_in.y >>> IDX;
  assign dy = vec_in.x >>> IDX;

  // Rotate towards the X axis; axis inputs pass through unchanged.
  always_comb begin
    vec_next = vec_in;
    if (!side_in.byp) begin
      if (!vec_in.y[XW-1]) begin
        vec_next.x = vec_in.x + dx;
        vec_next.y = vec_in.y - dy;
        vec_next.z = vec_in.z + Atan;
      end else begin
        vec_next.x = vec_in.x - dx;
        vec_next.y = vec_in.y + dy;
        vec_next.z = vec_in.z - Atan;
      end
    end
  end

  // The early cells share the CRC work, one byte each.
  generate
    if (IDX < 3) begin : g_crc
      localparam logic [1:0] Bsel = 2'(IDX);
      assign crc_next = crc8_byte(side_in.crc, side_in.rest[Bsel]);
    end else begin : g_nocrc
      assign crc_next = side_in.crc;
    end
  endgenerate

  always_comb begin
    side_next     = side_in;
    side_next.crc = crc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
    if (en) begin
      vec  <= vec_next;
      side <= side_next;
    end
  end

  // An axis input leaves the cell with its vector untouched.
  assert property (@(posedge clk) disable iff (rst)
    (en && vld_in && side_in.byp) |=> (vec == $past(vec_in)))
    else $error("sfca_cell: bypassed vector was modified");

endmodule

// ===== rtl/core/sfca_back.sv =====
// ----------------------------------------------------------------------------
// sfca_back: result stage
// Compares the inverted CRC with the check byte, rounds and limits the angle
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module sfca_back
  import sfca_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = AngleFracBitsDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               vld_in,
  input  sfca_vec_t          vec_in,
  input  sfca_side_t         side_in,
  output logic               out_valid,
  output logic               crc_ok,
  output logic signed [15:0] angle_deg
);

  localparam int Fb     = (ANGLE_FRAC_BITS > 12) ? 12 :
                          ((ANGLE_FRAC_BITS < 0) ? 0 : ANGLE_FRAC_BITS);
  localparam int Sh     = ZFRAC - Fb;
  localparam int Lim    = 180 << Fb;
  localparam int PosLim = (Lim > 32767) ? 32767 : Lim;
  localparam int NegLim = (Lim > 32768) ? 32768 : Lim;

  localparam logic signed [ZW:0] Half = (ZW+1)'(1 << (Sh - 1));
  localparam logic signed [ZW:0] PosW = (ZW+1)'(PosLim);
  localparam logic signed [ZW:0] NegW = -((ZW+1)'(NegLim));

  logic signed [ZW:0] a;
  logic signed [15:0] sat;
  logic               match;

  // Round half up to the output resolution, then clamp.
  always_comb begin
    a = {vec_in.z[ZW-1], vec_in.z} + Half;
    a = a >>> Sh;
    priority if (a > PosW) begin
      sat = 16'(PosLim);
    end else if (a < NegW) begin
      sat = 16'(-NegLim);
    end else begin
      sat = a[15:0];
    end
  end

  assign match = (~side_in.crc == side_in.crc_byte);

  // Output register; a failed check forces the angle to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld_in;
    end
    if (en) begin
      crc_ok    <= match;
      angle_deg <= match ? sat : '0;
    end
  end

endmodule

// ===== rtl/core/sensor_frame_crc_and_angle_unit.sv =====
// ----------------------------------------------------------------------------
// sensor_frame_crc_and_angle_unit: magnetometer frame check and angle
// A frame passes the entry register, the CORDIC cell registers and the output register.
// Throughput: one frame per cycle while the output is not held; the cell chain is fully pipelined.
// The whole chain stalls together while a result waits at the output.
// Reset clears all valid flags and loads the CRC seed with 0xFB.
// ----------------------------------------------------------------------------
module sensor_frame_crc_and_angle_unit
  import sfca_pkg::*;
#(
  parameter int CORDIC_STAGES   = CordicStagesDef,
  parameter int ANGLE_FRAC_BITS = AngleFracBitsDef
) (
  input  logic               clk,
  input  logic               rst,
  // Frame input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         x_low,
  input  logic [7:0]         x_high,
  input  logic [7:0]         y_low,
  input  logic [7:0]         y_high,
  input  logic [7:0]         crc_byte,
  // Result output
  output logic               out_valid,
  input  logic               out_ready,
  output logic               crc_ok,
  output logic signed [15:0] angle_deg,
  // Register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int Stages = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;

  logic        en;
  logic [7:0]  crc_seed;
  logic        vld  [Stages+1];
  sfca_vec_t   vec  [Stages+1];
  sfca_side_t  side [Stages+1];

  // The pipeline moves whenever the output register is free or being read.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Register port: one seed register, always ready.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegCrcSeed) ? {24'h000000, crc_seed} : 32'h0000_0000;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_seed <= SeedReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegCrcSeed)) begin
      crc_seed <= pwdata[7:0];
    end
  end

  // Entry stage.
  sfca_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .x_low    (x_low),
    .x_high   (x_high),
    .y_low    (y_low),
    .y_high   (y_high),
    .crc_byte (crc_byte),
    .crc_seed (crc_seed),
    .vld      (vld[0]),
    .vec      (vec[0]),
    .side     (side[0])
  );

  // Chain of CORDIC cells.
  generate
    for (genvar i = 0; i < Stages; i++) begin : g_cell
      sfca_cell #(
        .IDX (i)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .en      (en),
        .vld_in  (vld[i]),
        .vec_in  (vec[i]),
        .side_in (side[i]),
        .vld     (vld[i+1]),
        .vec     (vec[i+1]),
        .side    (side[i+1])
      );
    end
  endgenerate

  // Check, rounding and output register.
  sfca_back #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .vld_in    (vld[Stages]),
    .vec_in    (vec[Stages]),
    .side_in   (side[Stages]),
    .out_valid (out_valid),
    .crc_ok    (crc_ok),
    .angle_deg (angle_deg)
  );

  // A failed check never carries an angle.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !crc_ok) |-> (angle_deg == 16'sd0))
    else $error("angle reported for a frame with a bad check byte");

  // The angle never leaves the half turn on either side.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((angle_deg <= 16'sd23040) || (ANGLE_FRAC_BITS > 7)) &&
                  ((angle_deg >= -16'sd23040) || (ANGLE_FRAC_BITS > 7)))
    else $error("angle outside the half-turn range");

  // A result can only appear if a frame entered the chain earlier.
  assert property (@(posedge clk) disable iff (rst)
    (en && !vld[Stages]) |=> !out_valid)
    else $error("result produced without a frame in the last cell");

endmodule
